### hdl/tmfc_pkg.sv
// Shared types and constants for the tracker module format checker.
// Depends on nothing; every module of the checker imports it.
`timescale 1ns / 1ps
`default_nettype none

package tmfc_pkg;

   // Layout of the packed module file
   localparam int HEADER_END   = 564;
   localparam int LIST_LAST    = 129;
   localparam int RECORD_FIRST = 130;
   localparam int RECORD_BYTES = 14;

   // Queue between the front and back parts
   localparam int QUEUE_DEPTH     = 4;
   localparam int QUEUE_PTR_WIDTH = 2;

   // Offsets inside one 14-byte sample record
   localparam logic [3:0] REC_ADDR_0     = 4'd0;
   localparam logic [3:0] REC_ADDR_1     = 4'd1;
   localparam logic [3:0] REC_ADDR_2     = 4'd2;
   localparam logic [3:0] REC_ADDR_3     = 4'd3;
   localparam logic [3:0] REC_LEN_HI     = 4'd4;
   localparam logic [3:0] REC_LEN_LO     = 4'd5;
   localparam logic [3:0] REC_VOLUME     = 4'd7;
   localparam logic [3:0] REC_LOOP_0     = 4'd8;
   localparam logic [3:0] REC_LOOP_1     = 4'd9;
   localparam logic [3:0] REC_LOOP_2     = 4'd10;
   localparam logic [3:0] REC_LOOP_3     = 4'd11;
   localparam logic [3:0] REC_LOOP_LEN_HI = 4'd12;
   localparam logic [3:0] REC_LOOP_LEN_LO = 4'd13;
   localparam logic [3:0] REC_OFF_LAST   = 4'd13;

   // Offsets inside one four-byte pattern cell
   localparam logic [1:0] CELL_SAMPLE = 2'd0;
   localparam logic [1:0] CELL_NOTE   = 2'd1;
   localparam logic [1:0] CELL_EFFECT = 2'd2;
   localparam logic [1:0] CELL_VALUE  = 2'd3;

   // Limits
   localparam logic [7:0]  MAX_VOLUME   = 8'h40;
   localparam logic [7:0]  MAX_PATTERN  = 8'h7f;
   localparam logic [7:0]  MAX_NOTE     = 8'h48;
   localparam logic [7:0]  MAX_SAMPLE   = 8'h1f;
   localparam logic [7:0]  MAX_EFFECT_VALUE = 8'h40;
   localparam logic [7:0]  MAX_JUMP_VALUE   = 8'h7f;
   localparam logic [21:0] SAMPLE_LIMIT = 22'(31 * 65535);
   localparam logic [21:0] SAMPLE_MIN_EXCL = 22'd2;
   localparam logic [22:0] CONVERT_BASE = 23'd1084;

   // Effect codes that carry a bounded value
   localparam logic [3:0] EFFECT_JUMP   = 4'hb;
   localparam logic [3:0] EFFECT_VOLUME = 4'hc;
   localparam logic [3:0] EFFECT_BREAK  = 4'hd;

   // Region of the file that one byte falls in
   typedef enum logic [2:0] {
      KIND_COUNT,
      KIND_SKIP,
      KIND_LIST,
      KIND_RECORD,
      KIND_BODY
   } kind_type;

   // One classified byte as it travels from the front to the back part
   typedef struct packed {
      kind_type    kind;
      logic [6:0]  index;   // list entry number or record byte offset
      logic [7:0]  data;
      logic        last;
   } item_type;

endpackage

`default_nettype wire

### hdl/tmfc_front.sv
// Front part: tracks the byte position and classifies each byte by region.
// Depends on tmfc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tmfc_front #(
   parameter int POSITION_WIDTH = 32
) (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       push,
   input  wire                       full,
   input  wire  [7:0]                data_byte,
   input  wire                       last_byte,
   output logic                      wr_en,
   output tmfc_pkg::item_type        item,
   output logic [POSITION_WIDTH-1:0] pos
);
   import tmfc_pkg::*;

   logic [POSITION_WIDTH-1:0] pos_ff, pos_in;
   logic [3:0]                rec_off_ff, rec_off_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= '0;
         rec_off_ff <= '0;
      end else begin
         pos_ff     <= pos_in;
         rec_off_ff <= rec_off_in;
      end
   end

   always_comb begin
      item.data  = data_byte;
      item.last  = last_byte;
      item.index = '0;
      // classify by position
      if (pos_ff == '0) begin
         item.kind = KIND_COUNT;
      end else if (pos_ff == POSITION_WIDTH'(1)) begin
         item.kind = KIND_SKIP;
      end else if (pos_ff <= POSITION_WIDTH'(LIST_LAST)) begin
         item.kind  = KIND_LIST;
         item.index = pos_ff[6:0] - 7'd2;
      end else if (pos_ff < POSITION_WIDTH'(HEADER_END)) begin
         item.kind  = KIND_RECORD;
         item.index = {3'b000, rec_off_ff};
      end else begin
         item.kind = KIND_BODY;
      end

      wr_en      = push && !full;
      pos        = pos_ff;
      pos_in     = pos_ff;
      rec_off_in = rec_off_ff;
      if (wr_en) begin
         if (last_byte) begin
            pos_in     = '0;
            rec_off_in = '0;
         end else begin
            // saturate at the top
            if (pos_ff != '1) begin
               pos_in = pos_ff + POSITION_WIDTH'(1);
            end
            if (item.kind == KIND_RECORD) begin
               rec_off_in = (rec_off_ff == REC_OFF_LAST) ? 4'd0 : rec_off_ff + 4'd1;
            end
         end
      end
   end

endmodule

`default_nettype wire

### hdl/tmfc_queue.sv
// Short first-in first-out queue between the front and back parts.
// Depends on tmfc_pkg for depth and pointer width.
`timescale 1ns / 1ps
`default_nettype none

module tmfc_queue #(
   parameter int DATA_WIDTH = 51
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   wr_en,
   input  wire  [DATA_WIDTH-1:0] wr_data,
   output logic                  full,
   input  wire                   rd_en,
   output logic [DATA_WIDTH-1:0] rd_data,
   output logic                  empty
);
   import tmfc_pkg::*;

   logic [DATA_WIDTH-1:0]      entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_WIDTH-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_WIDTH-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_PTR_WIDTH:0]   count_ff, count_in;
   logic                       do_wr, do_rd;

   always_comb begin
      full      = (count_ff == (QUEUE_PTR_WIDTH+1)'(QUEUE_DEPTH));
      empty     = (count_ff == '0);
      do_wr     = wr_en && !full;
      do_rd     = rd_en && !empty;
      rd_data   = entry_ff[rd_ptr_ff];
      wr_ptr_in = do_wr ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_rd ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         entry_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

`default_nettype wire

### hdl/tmfc_back.sv
// Back part: runs the format checks, keeps the running totals and holds the
// verdict in a result register. Depends on tmfc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tmfc_back #(
   parameter int POSITION_WIDTH = 32
) (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       item_valid,
   input  tmfc_pkg::item_type        item,
   input  wire  [POSITION_WIDTH-1:0] pos,
   output logic                      item_take,
   output logic                      rsp_empty,
   input  wire                       rsp_pop,
   output logic                      rsp_accepted,
   output logic [22:0]               rsp_converted_size
);
   import tmfc_pkg::*;

   localparam int XW = POSITION_WIDTH + 1;

   logic        rejected_ff, rejected_in;
   logic [7:0]  list_count_ff, list_count_in;
   logic [6:0]  highest_ff, highest_in;
   logic [21:0] sample_total_ff, sample_total_in;
   logic [31:0] addr_ff, addr_in;
   logic [16:0] len_ff, len_in;
   logic [31:0] loop_addr_ff, loop_addr_in;
   logic [16:0] loop_len_ff, loop_len_in;
   logic [31:0] diff_ff, diff_in;
   logic        pre_fail_ff, pre_fail_in;
   logic [3:0]  effect_ff, effect_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic        acc_ff, acc_in;
   logic [22:0] size_ff, size_in;

   logic        fire, ok;
   logic [17:0] pattern_bytes;
   logic [22:0] body_start;
   logic [23:0] body_end;
   logic [XW-1:0] posx;
   logic        in_body;
   logic [1:0]  cell_off;
   logic [16:0] new_loop_len;
   logic [3:0]  rec_off;

   always_ff @(posedge clock) begin
      if (reset) begin
         rejected_ff     <= 1'b0;
         list_count_ff   <= '0;
         highest_ff      <= '0;
         sample_total_ff <= '0;
         effect_ff       <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         rejected_ff     <= rejected_in;
         list_count_ff   <= list_count_in;
         highest_ff      <= highest_in;
         sample_total_ff <= sample_total_in;
         effect_ff       <= effect_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff      <= addr_in;
      len_ff       <= len_in;
      loop_addr_ff <= loop_addr_in;
      loop_len_ff  <= loop_len_in;
      diff_ff      <= diff_in;
      pre_fail_ff  <= pre_fail_in;
      acc_ff       <= acc_in;
      size_ff      <= size_in;
   end

   always_comb begin
      // pattern region from the totals as they stand before this byte
      pattern_bytes = {({1'b0, highest_ff} + 8'd1), 10'b0};
      body_start    = 23'(HEADER_END) + {1'b0, sample_total_ff};
      body_end      = {1'b0, body_start} + 24'(pattern_bytes);
      posx          = {1'b0, pos};
      in_body       = (posx >= XW'(body_start)) && (posx < XW'(body_end));
      cell_off      = pos[1:0] - sample_total_ff[1:0];
      rec_off       = item.index[3:0];
      new_loop_len  = {loop_len_ff[16:9], item.data, 1'b0};

      // a verdict waits only for a free result register
      item_take = !item.last || !rsp_valid_ff || rsp_pop;
      fire      = item_valid && item_take;

      rejected_in     = rejected_ff;
      list_count_in   = list_count_ff;
      highest_in      = highest_ff;
      sample_total_in = sample_total_ff;
      addr_in         = addr_ff;
      len_in          = len_ff;
      loop_addr_in    = loop_addr_ff;
      loop_len_in     = loop_len_ff;
      diff_in         = diff_ff;
      pre_fail_in     = pre_fail_ff;
      effect_in       = effect_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_pop;
      acc_in          = acc_ff;
      size_in         = size_ff;
      ok              = 1'b0;

      if (fire) begin
         unique case (item.kind)
            KIND_COUNT: begin
               list_count_in = item.data;
            end
            KIND_SKIP: begin
            end
            KIND_LIST: begin
               if (item.data > MAX_PATTERN) begin
                  rejected_in = 1'b1;
               end else if (item.data[6:0] > highest_ff) begin
                  highest_in = item.data[6:0];
               end
               if (({2'b00, item.index} >= ({1'b0, list_count_ff} + 9'd2)) &&
                   (item.data != 8'd0)) begin
                  rejected_in = 1'b1;
               end
            end
            KIND_RECORD: begin
               unique case (rec_off)
                  REC_ADDR_0, REC_ADDR_1, REC_ADDR_2, REC_ADDR_3: begin
                     addr_in = {addr_ff[23:0], item.data};
                  end
                  REC_LEN_HI: begin
                     len_in = {item.data, 9'b0};
                  end
                  REC_LEN_LO: begin
                     len_in = {len_ff[16:9], item.data, 1'b0};
                  end
                  REC_VOLUME: begin
                     if (item.data > MAX_VOLUME) begin
                        rejected_in = 1'b1;
                     end
                  end
                  REC_LOOP_0, REC_LOOP_1, REC_LOOP_2, REC_LOOP_3: begin
                     loop_addr_in = {loop_addr_ff[23:0], item.data};
                  end
                  REC_LOOP_LEN_HI: begin
                     // addresses are complete: do the offset checks one byte early
                     loop_len_in = {item.data, 9'b0};
                     diff_in     = loop_addr_ff - addr_ff;
                     pre_fail_in = (loop_addr_ff < addr_ff) ||
                                   (addr_ff < 32'(HEADER_END)) ||
                                   (loop_addr_ff < 32'(HEADER_END)) ||
                                   ((loop_addr_ff - addr_ff) > {15'b0, len_ff});
                  end
                  REC_LOOP_LEN_LO: begin
                     loop_len_in = new_loop_len;
                     if (pre_fail_ff ||
                         (({1'b0, diff_ff} + 33'(new_loop_len)) > (33'(len_ff) + 33'd2))) begin
                        rejected_in = 1'b1;
                     end
                     sample_total_in = sample_total_ff + 22'(len_ff);
                  end
                  default: begin
                  end
               endcase
            end
            KIND_BODY: begin
               if (in_body) begin
                  unique case (cell_off)
                     CELL_SAMPLE: begin
                        if (item.data > MAX_SAMPLE) begin
                           rejected_in = 1'b1;
                        end
                     end
                     CELL_NOTE: begin
                        if ((item.data > MAX_NOTE) || item.data[0]) begin
                           rejected_in = 1'b1;
                        end
                     end
                     CELL_EFFECT: begin
                        effect_in = item.data[3:0];
                     end
                     CELL_VALUE: begin
                        if (((effect_ff == EFFECT_VOLUME) || (effect_ff == EFFECT_BREAK)) &&
                            (item.data > MAX_EFFECT_VALUE)) begin
                           rejected_in = 1'b1;
                        end
                        if ((effect_ff == EFFECT_JUMP) && (item.data > MAX_JUMP_VALUE)) begin
                           rejected_in = 1'b1;
                        end
                     end
                     default: begin
                     end
                  endcase
               end
            end
            default: begin
            end
         endcase

         if (item.last) begin
            ok = !rejected_in && (list_count_in != 8'd0) &&
                 (list_count_in <= MAX_PATTERN) &&
                 (sample_total_in > SAMPLE_MIN_EXCL) &&
                 (sample_total_in <= SAMPLE_LIMIT) &&
                 ((posx + XW'(1)) >= XW'(body_end));
            rsp_valid_in = 1'b1;
            acc_in       = ok;
            size_in      = ok ? (CONVERT_BASE + {1'b0, sample_total_in} + 23'(pattern_bytes))
                              : 23'd0;
            // restart for the next file
            rejected_in     = 1'b0;
            list_count_in   = '0;
            highest_in      = '0;
            sample_total_in = '0;
            effect_in       = '0;
            addr_in         = '0;
            len_in          = '0;
            loop_addr_in    = '0;
            loop_len_in     = '0;
         end
      end

      rsp_empty          = !rsp_valid_ff;
      rsp_accepted       = acc_ff;
      rsp_converted_size = size_ff;
   end

endmodule

`default_nettype wire

### hdl/tracker_module_format_checker.sv
// Top level of the tracker module format checker.
// Depends on tmfc_pkg, tmfc_front, tmfc_queue and tmfc_back.
//
// Usage:
//   Request channel: drive req_data_byte and req_last_byte with the next byte
//   of a packed four-channel module file and raise push; the byte is taken at
//   a rising edge with push high and full low. Mark the final byte of each
//   file with req_last_byte; the next byte after it starts a new file.
//   Result channel: one verdict per file. While empty is low, rsp_accepted and
//   rsp_converted_size show the oldest verdict; raise pop to take it.
// Throughput: one byte per clock cycle, sustained while full stays low. The front part counts the
//   position and classifies each byte, a four-entry queue decouples it from
//   the back part, which does all the checks for each byte.
// Verdict path: once its last byte is taken, a verdict shows after that byte has passed
//   the queue and then the result register, when nothing waits ahead of it.
// Stall: while a verdict waits untaken, bytes of the next file keep flowing;
//   only the next file's last byte waits, and once the queue fills, full
//   rises and holds off further requests.
// Reset: synchronous, active high; clears position, totals, the queue and
//   the result register. No clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module tracker_module_format_checker #(
   parameter int POSITION_WIDTH = 32
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         push,
   output logic        full,
   input  wire  [7:0]  req_data_byte,
   input  wire         req_last_byte,
   output logic        empty,
   input  wire         pop,
   output logic        rsp_accepted,
   output logic [22:0] rsp_converted_size
);
   import tmfc_pkg::*;

   localparam int QUEUE_WIDTH = $bits(item_type) + POSITION_WIDTH;
   localparam logic [22:0] MIN_ACCEPTED_SIZE = 23'd2112;

   logic                      wr_en;
   item_type                  front_item;
   logic [POSITION_WIDTH-1:0] front_pos;
   logic [QUEUE_WIDTH-1:0]    q_rd_data;
   logic                      q_empty;
   logic                      back_take;
   item_type                  back_item;
   logic [POSITION_WIDTH-1:0] back_pos;

   // classify bytes and advance the position
   tmfc_front #(
      .POSITION_WIDTH(POSITION_WIDTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .data_byte (req_data_byte),
      .last_byte (req_last_byte),
      .wr_en     (wr_en),
      .item      (front_item),
      .pos       (front_pos)
   );

   // hold classified bytes until the checker takes them
   tmfc_queue #(
      .DATA_WIDTH(QUEUE_WIDTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (wr_en),
      .wr_data ({front_pos, front_item}),
      .full    (full),
      .rd_en   (back_take),
      .rd_data (q_rd_data),
      .empty   (q_empty)
   );

   assign back_item = item_type'(q_rd_data[$bits(item_type)-1:0]);
   assign back_pos  = q_rd_data[QUEUE_WIDTH-1:$bits(item_type)];

   // run the checks and drive the verdict
   tmfc_back #(
      .POSITION_WIDTH(POSITION_WIDTH)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .item_valid         (!q_empty),
      .item               (back_item),
      .pos                (back_pos),
      .item_take          (back_take),
      .rsp_empty          (empty),
      .rsp_pop            (pop),
      .rsp_accepted       (rsp_accepted),
      .rsp_converted_size (rsp_converted_size)
   );

   // a rejected file always reports size zero
   a_reject_size : assert property (@(posedge clock) disable iff (reset)
      (!empty && !rsp_accepted) |-> (rsp_converted_size == 23'd0))
      else $error("rejected verdict with nonzero size");

   // an accepted file holds at least the header, four sample bytes and one pattern
   a_accept_size : assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_accepted) |-> (rsp_converted_size >= MIN_ACCEPTED_SIZE))
      else $error("accepted verdict with impossible size");

   // a taken last byte is queued for the checker on the next cycle
   a_last_queued : assert property (@(posedge clock) disable iff (reset)
      (push && !full && req_last_byte) |=> !q_empty)
      else $error("last byte lost between front and back");

   // no verdict appears while the checker has nothing to work on
   a_no_phantom : assert property (@(posedge clock) disable iff (reset)
      q_empty |=> !$fell(empty))
      else $error("verdict produced without a queued byte");

endmodule

`default_nettype wire

### dv/tmfc_checker.sv
// Checker for the tracker module format checker: watches both queue sides,
// predicts one verdict per file and compares it with what the block returns.
// Depends on tmfc_pkg for the file layout, offsets, limits and effect codes.
`timescale 1ns / 1ps

module tmfc_checker (
   input  wire         clock,
   input  wire         reset,
   input  wire         push,
   input  wire         full,
   input  wire  [7:0]  req_data_byte,
   input  wire         req_last_byte,
   input  wire         empty,
   input  wire         pop,
   input  wire         rsp_accepted,
   input  wire  [22:0] rsp_converted_size,
   output int          mismatch_count,
   output int          verdicts_owed
);
   import tmfc_pkg::*;

   typedef struct packed {
      logic        accepted;
      logic [22:0] size;
   } verdict_type;

   verdict_type owed_verdicts[$];

   // Predicted copy of the block's per-file state
   logic [31:0] position;
   logic [21:0] sample_total;
   logic [31:0] rec_address;
   logic [16:0] rec_length;
   logic [31:0] rec_loop_address;
   logic [16:0] rec_loop_length;
   logic [7:0]  list_count;
   logic [6:0]  highest_pattern;
   logic [3:0]  cell_effect;
   logic        rejected;

   task automatic clear_state();
      position         = '0;
      sample_total     = '0;
      rec_address      = '0;
      rec_length       = '0;
      rec_loop_address = '0;
      rec_loop_length  = '0;
      list_count       = '0;
      highest_pattern  = '0;
      cell_effect      = '0;
      rejected         = 1'b0;
   endtask

   // Advance the predicted state by one byte; queue a verdict on the last one.
   task automatic absorb_byte(input logic [7:0] b, input logic last);
      longint unsigned p, pat_bytes, start, k, m, l, n;
      logic [3:0] off;
      logic [1:0] slot;
      logic       ok;
      p         = position;
      pat_bytes = (longint'(highest_pattern) + 1) * 1024;
      start     = longint'(HEADER_END) + sample_total;
      if (p == 0) begin
         list_count = b;
      end else if (p >= 2 && p <= LIST_LAST) begin
         if (b > MAX_PATTERN) begin
            rejected = 1'b1;
         end else if (b[6:0] > highest_pattern) begin
            highest_pattern = b[6:0];
         end
         if (p - 2 >= longint'(list_count) + 2 && b != 8'd0) begin
            rejected = 1'b1;
         end
      end else if (p >= RECORD_FIRST && p < HEADER_END) begin
         off = 4'((p - RECORD_FIRST) % RECORD_BYTES);
         case (off)
            REC_ADDR_0, REC_ADDR_1, REC_ADDR_2, REC_ADDR_3: begin
               rec_address = {rec_address[23:0], b};
            end
            REC_LEN_HI: begin
               rec_length = {b, 9'd0};
            end
            REC_LEN_LO: begin
               rec_length = rec_length | {8'd0, b, 1'b0};
            end
            REC_VOLUME: begin
               if (b > MAX_VOLUME) rejected = 1'b1;
            end
            REC_LOOP_0, REC_LOOP_1, REC_LOOP_2, REC_LOOP_3: begin
               rec_loop_address = {rec_loop_address[23:0], b};
            end
            REC_LOOP_LEN_HI: begin
               rec_loop_length = {b, 9'd0};
            end
            REC_LOOP_LEN_LO: begin
               rec_loop_length = rec_loop_length | {8'd0, b, 1'b0};
               k = rec_address;
               m = rec_loop_address;
               l = rec_length;
               n = rec_loop_length;
               if (m < k || k < HEADER_END || m < HEADER_END) begin
                  rejected = 1'b1;
               end else if (m - k > l || (m - k) + n > l + 2) begin
                  rejected = 1'b1;
               end
               sample_total = sample_total + 22'(rec_length);
            end
            default: ;
         endcase
      end else if (p >= start && p < start + pat_bytes) begin
         slot = 2'(p - start);
         case (slot)
            CELL_SAMPLE: begin
               if (b > MAX_SAMPLE) rejected = 1'b1;
            end
            CELL_NOTE: begin
               if (b > MAX_NOTE || b[0]) rejected = 1'b1;
            end
            CELL_EFFECT: begin
               cell_effect = b[3:0];
            end
            default: begin
               if ((cell_effect == EFFECT_VOLUME || cell_effect == EFFECT_BREAK)
                   && b > MAX_EFFECT_VALUE) rejected = 1'b1;
               if (cell_effect == EFFECT_JUMP && b > MAX_JUMP_VALUE) rejected = 1'b1;
            end
         endcase
      end

      if (last) begin
         ok = !rejected && list_count != 8'd0 && list_count <= MAX_PATTERN
              && sample_total > SAMPLE_MIN_EXCL && sample_total <= SAMPLE_LIMIT
              && p + 1 >= start + pat_bytes;
         owed_verdicts.push_back('{accepted: ok,
            size: ok ? 23'(longint'(CONVERT_BASE) + sample_total + pat_bytes) : 23'd0});
         clear_state();
      end else if (position != '1) begin
         position = position + 1;
      end
   endtask

   always @(posedge clock) begin : watch
      verdict_type want;
      if (reset) begin
         clear_state();
         owed_verdicts.delete();
         mismatch_count = 0;
      end else begin
         if (pop && !empty) begin
            if (owed_verdicts.size() == 0) begin
               mismatch_count++;
               $display("%0t: verdict with none owed, actual accepted %0d size %0d",
                        $time, rsp_accepted, rsp_converted_size);
            end else begin
               want = owed_verdicts.pop_front();
               if (rsp_accepted !== want.accepted) begin
                  mismatch_count++;
                  $display("%0t: accepted mismatch, expected %0d actual %0d",
                           $time, want.accepted, rsp_accepted);
               end
               if (rsp_converted_size !== want.size) begin
                  mismatch_count++;
                  $display("%0t: converted_size mismatch, expected %0d actual %0d",
                           $time, want.size, rsp_converted_size);
               end
            end
         end
         if (push && !full) absorb_byte(req_data_byte, req_last_byte);
      end
      verdicts_owed <= owed_verdicts.size();
   end

endmodule

### dv/tb_top.sv
// Top of the testbench for the tracker module format checker: clock, reset,
// file stimulus, result-side pop pattern, watchdog and the final verdict.
// Depends on tmfc_pkg, the block itself and tmfc_checker.
`timescale 1ns / 1ps

module tb_top;
   import tmfc_pkg::*;

   localparam int HOLD_CYCLES  = 300;   // long receiver hold-off
   localparam int IDLE_LIMIT   = 3000;  // watchdog: cycles without any request moving
   localparam int RANDOM_FILES = 16;
   localparam int TAIL_CYCLES  = 8;

   logic        clock;
   logic        reset = 1'b1;
   logic        push = 1'b0;
   logic [7:0]  req_data_byte = 8'd0;
   logic        req_last_byte = 1'b0;
   logic        pop = 1'b0;
   logic        full;
   logic        empty;
   logic        rsp_accepted;
   logic [22:0] rsp_converted_size;

   // Phase flags, driven at the clock edge by the stimulus process
   logic quiet_phase = 1'b0;   // no idling on either side
   logic hold_phase  = 1'b0;   // receiver holds off once

   int mismatch_count;
   int verdicts_owed;

   // File under construction and the sample byte count it declares
   logic [7:0]  file_q[$];
   int unsigned file_samples;

   tracker_module_format_checker u_dut (
      .clock              (clock),
      .reset              (reset),
      .push               (push),
      .full               (full),
      .req_data_byte      (req_data_byte),
      .req_last_byte      (req_last_byte),
      .empty              (empty),
      .pop                (pop),
      .rsp_accepted       (rsp_accepted),
      .rsp_converted_size (rsp_converted_size)
   );

   tmfc_checker u_checker (
      .clock              (clock),
      .reset              (reset),
      .push               (push),
      .full               (full),
      .req_data_byte      (req_data_byte),
      .req_last_byte      (req_last_byte),
      .empty              (empty),
      .pop                (pop),
      .rsp_accepted       (rsp_accepted),
      .rsp_converted_size (rsp_converted_size),
      .mismatch_count     (mismatch_count),
      .verdicts_owed      (verdicts_owed)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // File construction
   // ------------------------------------------------------------------

   // Append a big-endian value of nbytes bytes.
   task automatic push_be(input logic [31:0] value, input int nbytes);
      for (int i = nbytes - 1; i >= 0; i--) file_q.push_back(value[8*i +: 8]);
   endtask

   // Build a well-formed module. top_pat is the highest pattern number.
   // A nonzero rec0_words fixes the first record's length and zeroes the rest,
   // so the sample total is exactly known; zero gives random lengths.
   task automatic build_module(input int top_pat, input int rec0_words);
      int unsigned count, slot, words, loop_off, loop_words, addr, total;
      logic [7:0]  eff;
      file_q.delete();
      count = $urandom_range(1, MAX_PATTERN);
      file_q.push_back(8'(count));
      file_q.push_back(8'($urandom));
      // place the highest pattern once inside the used part of the list
      slot = $urandom_range(0, (count + 1 > 127) ? 127 : count + 1);
      for (int e = 0; e < 128; e++) begin
         if (e == slot) file_q.push_back(8'(top_pat));
         else if (e < count + 2) file_q.push_back(8'($urandom_range(0, top_pat)));
         else file_q.push_back(8'd0);
      end
      total = 0;
      for (int r = 0; r < 31; r++) begin
         if (rec0_words != 0) words = (r == 0) ? rec0_words : 0;
         else if (r == 0) words = $urandom_range(2, 16);
         else words = ($urandom_range(99) < 70) ? 0 : $urandom_range(1, 20);
         // keep the loop inside the sample: offset <= length, end <= length + 2
         loop_off   = $urandom_range(0, words * 2);
         loop_words = $urandom_range(0, (words * 2 + 2 - loop_off) / 2);
         addr       = HEADER_END + $urandom_range(0, 32'hFFF0_0000);
         push_be(addr, 4);
         push_be(words, 2);
         file_q.push_back(8'($urandom));
         file_q.push_back(8'($urandom_range(0, MAX_VOLUME)));
         push_be(addr + loop_off, 4);
         push_be(loop_words, 2);
         total += words * 2;
      end
      file_samples = total;
      repeat (total) file_q.push_back(8'($urandom));
      // pattern cells with legal content
      repeat ((top_pat + 1) * 256) begin
         file_q.push_back(8'($urandom_range(0, MAX_SAMPLE)));
         file_q.push_back(8'(2 * $urandom_range(0, MAX_NOTE / 2)));
         eff = 8'($urandom);
         file_q.push_back(eff);
         case (eff[3:0])
            EFFECT_VOLUME, EFFECT_BREAK: file_q.push_back(8'($urandom_range(0, MAX_EFFECT_VALUE)));
            EFFECT_JUMP:                 file_q.push_back(8'($urandom_range(0, MAX_JUMP_VALUE)));
            default:                     file_q.push_back(8'($urandom));
         endcase
      end
   endtask

   // Point the loop of record r at (address + off) with the given word length.
   task automatic set_loop(input int r, input int off, input int words);
      int          base;
      logic [31:0] addr;
      base = RECORD_FIRST + RECORD_BYTES * r;
      addr = {file_q[base + REC_ADDR_0], file_q[base + REC_ADDR_1],
              file_q[base + REC_ADDR_2], file_q[base + REC_ADDR_3]};
      addr = addr + off;
      file_q[base + REC_LOOP_0]      = addr[31:24];
      file_q[base + REC_LOOP_1]      = addr[23:16];
      file_q[base + REC_LOOP_2]      = addr[15:8];
      file_q[base + REC_LOOP_3]      = addr[7:0];
      file_q[base + REC_LOOP_LEN_HI] = 8'(words >> 8);
      file_q[base + REC_LOOP_LEN_LO] = 8'(words);
   endtask

   // Overwrite pattern cell idx; the effect byte gets a random upper nibble.
   task automatic set_cell(input int idx, input logic [7:0] smp, input logic [7:0] note,
                           input logic [3:0] eff, input logic [7:0] val);
      int c;
      c = HEADER_END + file_samples + 4 * idx;
      file_q[c + CELL_SAMPLE] = smp;
      file_q[c + CELL_NOTE]   = note;
      file_q[c + CELL_EFFECT] = {4'($urandom), eff};
      file_q[c + CELL_VALUE]  = val;
   endtask

   // ------------------------------------------------------------------
   // Request side
   // ------------------------------------------------------------------

   // Offer one byte and hold it until the block takes it. Entered and left
   // at a rising edge; the sender idles at random outside the quiet phase.
   task automatic send_byte(input logic [7:0] b, input logic last);
      while (!quiet_phase && $urandom_range(99) < 15) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push          <= 1'b1;
      req_data_byte <= b;
      req_last_byte <= last;
      @(posedge clock);
      while (full) @(posedge clock);
   endtask

   task automatic send_file();
      for (int i = 0; i < file_q.size(); i++) send_byte(file_q[i], i == file_q.size() - 1);
   endtask

   // Drop push and wait until every owed verdict has been popped.
   task automatic drain();
      push <= 1'b0;
      do @(posedge clock); while (verdicts_owed != 0);
   endtask

   int base0;
   int len0;

   initial begin
      // hold reset from time zero, then release it at a rising edge
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // ---------------- short files ----------------
      // one byte only, then a file that ends inside the sample records
      file_q.delete();
      file_q.push_back(8'd1);
      send_file();
      build_module(0, 0);
      file_q = file_q[0:149];
      send_file();

      // ---------------- no idling on either side ----------------
      // one complete file with the limits met exactly: top list count, top
      // volume, loop at the end of its sample, cell values at their bounds,
      // and trailing bytes after the pattern region
      base0 = RECORD_FIRST;
      build_module(0, 2);
      file_q[0] = MAX_PATTERN;
      file_q[RECORD_FIRST + RECORD_BYTES * 5 + REC_VOLUME] = MAX_VOLUME;
      len0 = 2 * {file_q[base0 + REC_LEN_HI], file_q[base0 + REC_LEN_LO]};
      set_loop(0, len0, 1);
      set_cell(0, MAX_SAMPLE, MAX_NOTE, EFFECT_VOLUME, MAX_EFFECT_VALUE);
      set_cell(1, 8'd0, 8'd0, EFFECT_BREAK, MAX_EFFECT_VALUE);
      set_cell(2, 8'd0, 8'd0, EFFECT_JUMP, MAX_JUMP_VALUE);
      repeat (5) file_q.push_back(8'($urandom));
      quiet_phase <= 1'b1;
      send_file();
      quiet_phase <= 1'b0;
      drain();

      // ---------------- receiver hold-off ----------------
      // keep offering tiny files so verdicts pile up and full rises
      hold_phase <= 1'b1;
      repeat (12) begin
         file_q.delete();
         repeat ($urandom_range(1, 3)) file_q.push_back(8'($urandom));
         send_file();
      end
      hold_phase <= 1'b0;
      drain();

      // ---------------- random short files ----------------
      for (int f = 0; f < RANDOM_FILES; f++) begin
         file_q.delete();
         repeat ($urandom_range(1, 8)) file_q.push_back(8'($urandom));
         if ($urandom_range(9) == 0) drain();
         send_file();
      end

      // ---------------- wind down ----------------
      drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   // ------------------------------------------------------------------
   // Result side: pop at random, hold off once for a long stretch
   // ------------------------------------------------------------------
   int  hold_left;
   logic hold_seen;

   always @(posedge clock) begin
      if (reset) begin
         pop       <= 1'b0;
         hold_left <= 0;
         hold_seen <= 1'b0;
      end else if (hold_phase && !hold_seen) begin
         hold_seen <= 1'b1;
         hold_left <= HOLD_CYCLES;
         pop       <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         pop       <= 1'b0;
      end else begin
         pop <= quiet_phase || ($urandom_range(99) >= 15);
      end
   end

   // ------------------------------------------------------------------
   // Watchdog: count cycles in which no request moves on either side
   // ------------------------------------------------------------------
   int idle_cycles = 0;

   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule
